FILE: src/aes_pkg.sv
// ----------------------------------------------------------------------------
// aes_pkg: shared types and constants of the escape sequence stripper
// Parser states, character codes and the decode result record.
// ----------------------------------------------------------------------------
package aes_pkg;

	localparam int UNIT_WIDTH_DEF = 16;

	// character codes, all below 0x80 so they fit any unit width of 7 bits or more
	localparam logic [7:0] CH_BEL       = 8'h07;
	localparam logic [7:0] CH_TAB       = 8'h09;
	localparam logic [7:0] CH_LF        = 8'h0A;
	localparam logic [7:0] CH_CR        = 8'h0D;
	localparam logic [7:0] CH_ESC       = 8'h1B;
	localparam logic [7:0] CH_SPACE     = 8'h20;
	localparam logic [7:0] CH_DEL       = 8'h7F;
	localparam logic [7:0] CH_AT        = 8'h40;
	localparam logic [7:0] CH_TILDE     = 8'h7E;
	localparam logic [7:0] CH_LBRACKET  = 8'h5B;
	localparam logic [7:0] CH_RBRACKET  = 8'h5D;
	localparam logic [7:0] CH_P         = 8'h50;
	localparam logic [7:0] CH_CARET     = 8'h5E;
	localparam logic [7:0] CH_UNDERLINE = 8'h5F;
	localparam logic [7:0] CH_BACKSLASH = 8'h5C;

	typedef enum logic [4:0] {
		ST_NORMAL     = 5'b00001,
		ST_ESCAPE     = 5'b00010,
		ST_CSI        = 5'b00100,
		ST_STRING     = 5'b01000,
		ST_STRING_ESC = 5'b10000
	} parse_state_t;

	// decode result for one unit
	typedef struct packed {
		parse_state_t next_state;
		logic         emit;
		logic         to_lf;
	} step_t;

endpackage

FILE: src/aes_in_if.sv
// ----------------------------------------------------------------------------
// aes_in_if: input channel of the escape sequence stripper
// Valid/ready channel carrying one raw text code unit.
// ----------------------------------------------------------------------------
interface aes_in_if #(
	parameter int UNIT_WIDTH = 16
);
	logic                  valid;
	logic                  ready;
	logic [UNIT_WIDTH-1:0] code_unit;

	modport source (output valid, output code_unit, input ready);
	modport sink   (input valid, input code_unit, output ready);
endinterface

FILE: src/aes_out_if.sv
// ----------------------------------------------------------------------------
// aes_out_if: output channel of the escape sequence stripper
// Valid/ready channel carrying one cleaned text code unit.
// ----------------------------------------------------------------------------
interface aes_out_if #(
	parameter int UNIT_WIDTH = 16
);
	logic                  valid;
	logic                  ready;
	logic [UNIT_WIDTH-1:0] clean_unit;

	modport source (output valid, output clean_unit, input ready);
	modport sink   (input valid, input clean_unit, output ready);
endinterface

FILE: src/aes_decode.sv
// ----------------------------------------------------------------------------
// aes_decode: parser step of the escape sequence stripper
// Given the current state and one unit, gives next state and whether to emit.
// ----------------------------------------------------------------------------
module aes_decode #(
	parameter int UNIT_WIDTH = aes_pkg::UNIT_WIDTH_DEF
) (
	input  aes_pkg::parse_state_t  state,
	input  logic [UNIT_WIDTH-1:0]  unit,
	output aes_pkg::step_t         step
);
	import aes_pkg::*;

	function automatic logic is_ch(input logic [UNIT_WIDTH-1:0] u, input logic [7:0] c);
		return u == UNIT_WIDTH'(c);
	endfunction

	logic is_ctrl;
	logic is_csi_end;
	logic is_str_open;

	assign is_ctrl     = (unit < UNIT_WIDTH'(CH_SPACE)) || is_ch(unit, CH_DEL);
	assign is_csi_end  = (unit >= UNIT_WIDTH'(CH_AT)) && (unit <= UNIT_WIDTH'(CH_TILDE));
	assign is_str_open = is_ch(unit, CH_RBRACKET) || is_ch(unit, CH_P) ||
	                     is_ch(unit, CH_CARET) || is_ch(unit, CH_UNDERLINE);

	always_comb begin
		step.next_state = ST_NORMAL;
		step.emit       = 1'b0;
		step.to_lf      = 1'b0;
		unique case (state)
			ST_ESCAPE: begin
				if (is_ch(unit, CH_LBRACKET)) begin
					step.next_state = ST_CSI;
				end else if (is_str_open) begin
					step.next_state = ST_STRING;
				end
			end
			ST_CSI: begin
				step.next_state = is_csi_end ? ST_NORMAL : ST_CSI;
			end
			ST_STRING: begin
				if (is_ch(unit, CH_BEL)) begin
					step.next_state = ST_NORMAL;
				end else if (is_ch(unit, CH_ESC)) begin
					step.next_state = ST_STRING_ESC;
				end else begin
					step.next_state = ST_STRING;
				end
			end
			ST_STRING_ESC: begin
				if (is_ch(unit, CH_BACKSLASH) || is_ch(unit, CH_BEL)) begin
					step.next_state = ST_NORMAL;
				end else if (is_ch(unit, CH_ESC)) begin
					step.next_state = ST_STRING_ESC;
				end else begin
					step.next_state = ST_STRING;
				end
			end
			default: begin
				// plain text, and any stray code
				if (is_ch(unit, CH_ESC)) begin
					step.next_state = ST_ESCAPE;
				end else if (is_ch(unit, CH_CR)) begin
					step.emit  = 1'b1;
					step.to_lf = 1'b1;
				end else begin
					step.emit = is_ch(unit, CH_LF) || is_ch(unit, CH_TAB) || !is_ctrl;
				end
			end
		endcase
	end
endmodule

FILE: src/aes_out_stage.sv
// ----------------------------------------------------------------------------
// aes_out_stage: result register of the escape sequence stripper
// Holds one cleaned unit until the sink takes it; loads when it advances.
// ----------------------------------------------------------------------------
module aes_out_stage #(
	parameter int UNIT_WIDTH = aes_pkg::UNIT_WIDTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  load,
	input  aes_pkg::step_t        step,
	input  logic [UNIT_WIDTH-1:0] unit,
	output logic                  advance,
	aes_out_if.source             tx
);
	import aes_pkg::*;

	logic                  valid_s2;
	logic [UNIT_WIDTH-1:0] unit_s2;

	assign advance = !valid_s2 || tx.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= load && step.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && load) begin
			unit_s2 <= step.to_lf ? UNIT_WIDTH'(CH_LF) : unit;
		end
	end

	assign tx.valid      = valid_s2;
	assign tx.clean_unit = unit_s2;
endmodule

FILE: src/ansi_escape_stripper.sv
// ----------------------------------------------------------------------------
// ansi_escape_stripper: removes ANSI/VT escape sequences from a text stream
// Registered input, one-unit parser step, registered output.
// ----------------------------------------------------------------------------
// Takes one code unit per cycle while the output is not stalled; each unit passes the input
// register and gives at most one cleaned unit in the result register. CSI, two-unit escapes and
// string sequences (OSC, DCS, PM, APC) are removed, control units other than LF and TAB are
// dropped and CR comes out as LF. Throughput is one unit per clock while the output is not stalled,
// set by the parser state update between the input register and the result register; a stalled output holds both.
module ansi_escape_stripper #(
	parameter int UNIT_WIDTH = aes_pkg::UNIT_WIDTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	aes_in_if.sink    rx,
	aes_out_if.source tx
);
	import aes_pkg::*;

	logic                  valid_s1;
	logic [UNIT_WIDTH-1:0] unit_s1;
	parse_state_t          state_q;
	step_t                 step;
	logic                  advance;
	logic                  consume;

	assign consume  = valid_s1 && advance;
	assign rx.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.ready) begin
			valid_s1 <= rx.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.ready && rx.valid) begin
			unit_s1 <= rx.code_unit;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_NORMAL;
		end else if (consume) begin
			state_q <= step.next_state;
		end
	end

	aes_decode #(
		.UNIT_WIDTH(UNIT_WIDTH)
	) u_decode (
		.state(state_q),
		.unit (unit_s1),
		.step (step)
	);

	aes_out_stage #(
		.UNIT_WIDTH(UNIT_WIDTH)
	) u_out (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (consume),
		.step   (step),
		.unit   (unit_s1),
		.advance(advance),
		.tx     (tx)
	);

	a_state_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(state_q))
		else $error("parser state lost its one-hot code");

	a_new_result_from_s1: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(tx.valid) |-> $past(valid_s1))
		else $error("result appeared without a request in the input register");

	a_drop_in_sequence: assert property (@(posedge clk) disable iff (!arst_n)
		(consume && state_q != ST_NORMAL) |=> !tx.valid)
		else $error("unit inside an escape sequence was emitted");

	a_no_cr_out: assert property (@(posedge clk) disable iff (!arst_n)
		tx.valid |-> (tx.clean_unit != UNIT_WIDTH'(CH_CR) &&
		              tx.clean_unit != UNIT_WIDTH'(CH_ESC)))
		else $error("CR or ESC reached the output");
endmodule

FILE: verif/tb_ansi_escape_stripper.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ansi_escape_stripper: self-checking bench for the escape sequence stripper
// Feeds directed and random text streams (plain text, CSI, string sequences,
// short escapes, raw noise) through the valid/ready input with random gaps and
// output stalls. A scoreboard tracks the parser state and checks each cleaned
// unit in order.
// ----------------------------------------------------------------------------
module tb_ansi_escape_stripper;
	import aes_pkg::*;

	localparam int UW          = UNIT_WIDTH_DEF;
	localparam int CYCLE_LIMIT = 200000;
	localparam int LONG_HOLD   = 300;
	localparam int RANDOM_LEN  = 900;

	class strip_ledger;
		parse_state_t  mode;
		logic [UW-1:0] expected_units[$];
		int            errors;

		function new();
			mode   = ST_NORMAL;
			errors = 0;
		endfunction

		function int pending();
			return expected_units.size();
		endfunction

		// one accepted input request: step the parser, queue any cleaned unit
		function void note_request(logic [UW-1:0] u);
			logic [UW-1:0] lf;
			lf = UW'(CH_LF);
			case (mode)
				ST_ESCAPE: begin
					if (u == CH_LBRACKET)
						mode = ST_CSI;
					else if (u == CH_RBRACKET || u == CH_P || u == CH_CARET ||
							u == CH_UNDERLINE)
						mode = ST_STRING;
					else
						mode = ST_NORMAL;
				end
				ST_CSI: begin
					if (u >= CH_AT && u <= CH_TILDE)
						mode = ST_NORMAL;
				end
				ST_STRING: begin
					if (u == CH_BEL)
						mode = ST_NORMAL;
					else if (u == CH_ESC)
						mode = ST_STRING_ESC;
				end
				ST_STRING_ESC: begin
					if (u == CH_BACKSLASH || u == CH_BEL)
						mode = ST_NORMAL;
					else if (u != CH_ESC)
						mode = ST_STRING;
				end
				default: begin
					mode = ST_NORMAL;
					if (u == CH_ESC)
						mode = ST_ESCAPE;
					else if (u == CH_CR)
						expected_units.push_back(lf);
					else if (u == CH_LF || u == CH_TAB || !(u < CH_SPACE || u == CH_DEL))
						expected_units.push_back(u);
				end
			endcase
		endfunction

		function void check_result(logic [UW-1:0] got);
			logic [UW-1:0] want;
			if (expected_units.size() == 0) begin
				errors++;
				$display("%0t: unexpected clean_unit: expected none, actual %h", $time, got);
			end else begin
				want = expected_units.pop_front();
				if (got !== want) begin
					errors++;
					$display("%0t: clean_unit mismatch: expected %h, actual %h",
						$time, want, got);
				end
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;

	aes_in_if  #(.UNIT_WIDTH(UW)) in_ch ();
	aes_out_if #(.UNIT_WIDTH(UW)) out_ch ();

	ansi_escape_stripper #(.UNIT_WIDTH(UW)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.rx     (in_ch),
		.tx     (out_ch)
	);

	strip_ledger   ledger;
	logic [UW-1:0] raw_stream[$];
	int            sent_count;
	int            taken_count;
	bit            send_burst;
	bit            take_burst;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// ---------------- stream builders ----------------

	function automatic void add_text();
		int          n;
		int unsigned pick;
		n = $urandom_range(1, 8);
		repeat (n) begin
			pick = $urandom_range(0, 15);
			if (pick < 9)
				raw_stream.push_back(UW'($urandom_range(16'h20, 16'h7E)));
			else if (pick < 11)
				raw_stream.push_back(UW'($urandom_range(16'h80, 16'hFFFF)));
			else if (pick == 11)
				raw_stream.push_back(UW'(CH_CR));
			else if (pick == 12)
				raw_stream.push_back(UW'(CH_LF));
			else if (pick == 13)
				raw_stream.push_back(UW'(CH_TAB));
			else if (pick == 14)
				raw_stream.push_back(UW'(CH_DEL));
			else
				raw_stream.push_back(UW'($urandom_range(0, 16'h1F))); // may open a sequence
		end
	endfunction

	function automatic void add_csi();
		int n;
		raw_stream.push_back(UW'(CH_ESC));
		raw_stream.push_back(UW'(CH_LBRACKET));
		n = $urandom_range(0, 4);
		repeat (n) raw_stream.push_back(UW'($urandom_range(16'h30, 16'h3F)));
		if ($urandom_range(0, 1))
			raw_stream.push_back(UW'($urandom_range(16'h20, 16'h2F)));
		// stray control or DEL never ends a CSI
		if ($urandom_range(0, 7) == 0)
			raw_stream.push_back(UW'($urandom_range(0, 1) ? CH_DEL : CH_CR));
		raw_stream.push_back(UW'($urandom_range(CH_AT, CH_TILDE)));
	endfunction

	function automatic void add_string_seq();
		int          n;
		int unsigned pick;
		raw_stream.push_back(UW'(CH_ESC));
		case ($urandom_range(0, 3))
			0: raw_stream.push_back(UW'(CH_RBRACKET));
			1: raw_stream.push_back(UW'(CH_P));
			2: raw_stream.push_back(UW'(CH_CARET));
			default: raw_stream.push_back(UW'(CH_UNDERLINE));
		endcase
		n = $urandom_range(0, 8);
		repeat (n) begin
			pick = $urandom_range(0, 15);
			if (pick < 13) begin
				raw_stream.push_back(UW'($urandom_range(16'h20, 16'hFFFF)));
			end else if (pick < 15) begin
				// ESC not followed by backslash falls back into the string
				raw_stream.push_back(UW'(CH_ESC));
				raw_stream.push_back(UW'($urandom_range(16'h20, 16'h5B)));
			end else begin
				raw_stream.push_back(UW'(CH_ESC));
				raw_stream.push_back(UW'(CH_ESC));
			end
		end
		case ($urandom_range(0, 3))
			0: raw_stream.push_back(UW'(CH_BEL));
			1: begin
				raw_stream.push_back(UW'(CH_ESC));
				raw_stream.push_back(UW'(CH_BACKSLASH));
			end
			2: begin
				raw_stream.push_back(UW'(CH_ESC));
				raw_stream.push_back(UW'(CH_BEL));
			end
			default: begin
				raw_stream.push_back(UW'(CH_ESC));
				raw_stream.push_back(UW'(CH_ESC));
				raw_stream.push_back(UW'(CH_BACKSLASH));
			end
		endcase
	endfunction

	function automatic void add_noise();
		int n;
		n = $urandom_range(1, 4);
		repeat (n) raw_stream.push_back(UW'($urandom_range(0, 16'hFFFF)));
	endfunction

	function automatic void add_random_piece();
		int unsigned pick;
		pick = $urandom_range(0, 15);
		if (pick < 5) begin
			add_text();
		end else if (pick < 8) begin
			add_csi();
		end else if (pick < 11) begin
			add_string_seq();
		end else if (pick < 13) begin
			// two-unit escape, second unit may also open a sequence
			raw_stream.push_back(UW'(CH_ESC));
			raw_stream.push_back(UW'($urandom_range(16'h20, 16'h7E)));
		end else begin
			add_noise();
		end
	endfunction

	function automatic void add_directed();
		// field extremes and plain-text handling
		raw_stream.push_back(16'h0000);
		raw_stream.push_back(16'hFFFF);
		raw_stream.push_back(UW'(CH_CR));
		raw_stream.push_back(UW'(CH_LF));
		raw_stream.push_back(UW'(CH_TAB));
		raw_stream.push_back(UW'(CH_DEL));
		raw_stream.push_back(UW'(CH_SPACE));
		// ESC ESC ends as a two-unit escape
		raw_stream.push_back(UW'(CH_ESC));
		raw_stream.push_back(UW'(CH_ESC));
		// CSI with DEL inside, ended by the lowest final
		raw_stream.push_back(UW'(CH_ESC));
		raw_stream.push_back(UW'(CH_LBRACKET));
		raw_stream.push_back(UW'(CH_DEL));
		raw_stream.push_back(UW'(CH_AT));
		// OSC ended by BEL
		raw_stream.push_back(UW'(CH_ESC));
		raw_stream.push_back(UW'(CH_RBRACKET));
		raw_stream.push_back(UW'(CH_BEL));
		// DCS with ESC ESC and ESC other inside, ended by ESC backslash
		raw_stream.push_back(UW'(CH_ESC));
		raw_stream.push_back(UW'(CH_P));
		raw_stream.push_back(UW'(CH_ESC));
		raw_stream.push_back(UW'(CH_ESC));
		raw_stream.push_back(16'h0071);
		raw_stream.push_back(UW'(CH_ESC));
		raw_stream.push_back(UW'(CH_BACKSLASH));
		// APC ended by ESC BEL
		raw_stream.push_back(UW'(CH_ESC));
		raw_stream.push_back(UW'(CH_UNDERLINE));
		raw_stream.push_back(UW'(CH_ESC));
		raw_stream.push_back(UW'(CH_BEL));
		// CR right after ESC is swallowed
		raw_stream.push_back(UW'(CH_ESC));
		raw_stream.push_back(UW'(CH_CR));
	endfunction

	// ---------------- drivers ----------------

	task automatic send_unit(input logic [UW-1:0] u);
		int unsigned gap;
		logic        rdy_seen;
		if (sent_count % 64 == 0)
			send_burst = ($urandom_range(0, 3) == 0);
		gap = send_burst ? 0 : $urandom_range(0, 12);
		if (gap != 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid     <= 1'b1;
		in_ch.code_unit <= u;
		// ready is stable between the falling edge and the next rising edge
		do begin
			@(negedge clk);
			rdy_seen = in_ch.ready;
			@(posedge clk);
		end while (rdy_seen !== 1'b1);
		ledger.note_request(u);
		sent_count++;
	endtask

	task automatic pause_until_drained();
		in_ch.valid <= 1'b0;
		do @(posedge clk); while (ledger.pending() != 0);
		@(posedge clk);
	endtask

	task automatic take_results();
		int unsigned   hold;
		logic          vld_seen;
		logic [UW-1:0] got;
		forever begin
			if (taken_count % 64 == 0)
				take_burst = ($urandom_range(0, 3) == 0);
			// one long hold-off so the block backs up into its input
			if (taken_count == 120)
				hold = LONG_HOLD;
			else
				hold = take_burst ? 0 : $urandom_range(0, 12);
			if (hold != 0) begin
				out_ch.ready <= 1'b0;
				repeat (hold) @(posedge clk);
			end
			out_ch.ready <= 1'b1;
			do begin
				@(negedge clk);
				vld_seen = out_ch.valid;
				got      = out_ch.clean_unit;
				@(posedge clk);
			end while (vld_seen !== 1'b1);
			ledger.check_result(got);
			taken_count++;
		end
	endtask

	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("Mismatches found");
		$finish;
	end

	initial begin
		int directed_count;
		arst_n          <= 1'b0;
		in_ch.valid     <= 1'b0;
		in_ch.code_unit <= '0;
		out_ch.ready    <= 1'b0;
		sent_count  = 0;
		taken_count = 0;
		send_burst  = 1'b0;
		take_burst  = 1'b0;
		ledger = new();

		add_directed();
		directed_count = raw_stream.size();
		while (raw_stream.size() < directed_count + RANDOM_LEN)
			add_random_piece();
		// unfinished string sequence at the very end, never flushed
		raw_stream.push_back(UW'(CH_ESC));
		raw_stream.push_back(UW'(CH_RBRACKET));
		raw_stream.push_back(16'h0061);
		raw_stream.push_back(16'h0062);

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		fork
			take_results();
		join_none

		for (int i = 0; i < raw_stream.size(); i++) begin
			if (i == directed_count || i == directed_count + RANDOM_LEN / 2)
				pause_until_drained();
			send_unit(raw_stream[i]);
		end
		in_ch.valid <= 1'b0;

		while (ledger.pending() != 0) @(posedge clk);
		repeat (10) @(posedge clk);

		if (ledger.errors == 0 && ledger.pending() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
